[src/tfp_pkg.sv]
// Shared types and constants for the temperature frame parser.
package tfp_pkg;

    // Header register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_HDR_ONE   = 2'd0,
        CFG_HDR_TWO   = 2'd1,
        CFG_HDR_THREE = 2'd2,
        CFG_HDR_FOUR  = 2'd3
    } t_cfg_idx;

    localparam int unsigned HdrCount   = 4;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned TempW      = 15;
    localparam int unsigned MagW       = 14;

    // Frame offsets of the temperature bytes
    localparam int unsigned IntOffset  = 6;
    localparam int unsigned FracOffset = 7;

    // Integer byte: bit 7 is the sign, bits 6:0 whole degrees
    localparam int unsigned SignBit    = 7;
    localparam int unsigned ScaleHundr = 100;

    typedef logic [ByteW-1:0]        t_byte;
    typedef logic signed [TempW-1:0] t_temp;
    typedef logic [MagW-1:0]         t_mag;

endpackage

[src/temperature_frame_parser_core.sv]
// Serial sensor frame parser: header hunt, additive checksum, temperature output.
//
// Usage:
//   Input channel: one received serial byte per request on i_rx_byte, qualified by
//   i_in_valid and throttled by o_in_stall. Output channel: one signed temperature
//   in hundredths of a degree per good frame on o_temperature_hundredths, qualified
//   by o_out_valid and throttled by i_out_stall. Bytes that do not end a good frame
//   give no output request; bad frames are dropped without notice.
//   Configuration: i_cfg_we writes i_cfg_data into header register i_cfg_index
//   (0..3 = expected frame bytes at offsets 0..3). Write only while idle.
// Timing:
//   A byte lands in the input register, then the parsing logic updates the frame
//   state and loads the result register, which drives o_out_valid. One byte is
//   taken every cycle while the output side keeps up. The result register is the
//   only output buffer, so a stall on the output side holds the parse stage and
//   backs up into o_in_stall.
// Reset:
//   Synchronous, active low. Clears header registers, frame position and sum,
//   and both valid flags; the parser starts hunting for header byte one.
module temperature_frame_parser_core #(
    parameter int unsigned FRAME_LENGTH = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tfp_pkg::t_byte       i_rx_byte,
    // temperature output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tfp_pkg::t_temp       o_temperature_hundredths,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  tfp_pkg::t_byte       i_cfg_data
);
    import tfp_pkg::*;

    // Position counter holds 0..FRAME_LENGTH-1
    localparam int unsigned PosW = $clog2(FRAME_LENGTH);
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);

    // Header registers
    t_byte r_hdr [HdrCount];

    // Input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // Frame state
    logic [PosW-1:0] r_pos,  n_pos;
    t_byte           r_sum,  n_sum;
    t_byte           r_int,  n_int;
    t_byte           r_frac, n_frac;

    // Result register
    logic  r_out_valid;
    t_temp r_temp;

    logic  out_free;
    logic  adv;
    logic  in_ready;
    logic  in_acc;
    logic  hdr_miss;
    logic  emit;
    t_mag  mag;
    t_temp temp_val;

    // ---------------------------------------------------------------
    // Handshake: parse stage moves when the result register can take it
    // ---------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign in_ready   = !r_in_valid || adv;
    assign in_acc     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HdrCount; k++) begin
                r_hdr[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HDR_ONE:   r_hdr[0] <= i_cfg_data;
                CFG_HDR_TWO:   r_hdr[1] <= i_cfg_data;
                CFG_HDR_THREE: r_hdr[2] <= i_cfg_data;
                CFG_HDR_FOUR:  r_hdr[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // ---------------------------------------------------------------
    // Parse step: header hunt, byte capture, checksum
    // ---------------------------------------------------------------
    assign hdr_miss = (r_pos == PosW'(1) && r_in_byte != r_hdr[1]) ||
                      (r_pos == PosW'(2) && r_in_byte != r_hdr[2]) ||
                      (r_pos == PosW'(3) && r_in_byte != r_hdr[3]);

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_int  = r_int;
        n_frac = r_frac;
        emit   = 1'b0;
        if (adv) begin
            if (r_pos == '0 || hdr_miss) begin
                // restart: keep the byte only if it can open a frame
                if (r_in_byte == r_hdr[0]) begin
                    n_pos = PosW'(1);
                    n_sum = r_in_byte;
                end else begin
                    n_pos = '0;
                    n_sum = '0;
                end
            end else if (r_pos == LastPos) begin
                n_pos = '0;
                n_sum = '0;
                emit  = (r_sum == r_in_byte);
            end else begin
                if (r_pos == PosW'(IntOffset)) begin
                    n_int = r_in_byte;
                end
                if (r_pos == PosW'(FracOffset)) begin
                    n_frac = r_in_byte;
                end
                n_sum = r_sum + r_in_byte;
                n_pos = r_pos + PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_int  <= '0;
            r_frac <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_int  <= n_int;
            r_frac <= n_frac;
        end
    end

    // ---------------------------------------------------------------
    // Temperature: (int & 0x7f) * 100 + frac, negated by the sign bit
    // ---------------------------------------------------------------
    assign mag = MagW'(r_int[SignBit-1:0]) * MagW'(ScaleHundr) + MagW'(r_frac);
    assign temp_val = r_int[SignBit] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_temp <= temp_val;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_temperature_hundredths = r_temp;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LastPos)
        else $error("frame position past last byte");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_pos == LastPos) |=> (r_pos == '0 && r_sum == '0))
        else $error("frame state not cleared after last byte");

    a_hdr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && hdr_miss) |=> (r_pos == '0 || r_pos == PosW'(1)))
        else $error("header mismatch did not restart frame");

    a_open_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_pos == '0 && r_in_byte == r_hdr[0])
            |=> (r_pos == PosW'(1) && r_sum == $past(r_in_byte)))
        else $error("frame start not seeded with header byte");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule

[sim/temperature_frame_parser_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for temperature_frame_parser_core: frame predictor, stimulus, checks.
module temperature_frame_parser_core_test;
    import tfp_pkg::*;

    localparam int unsigned FRAME_LEN     = 9;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT   = 200;  // cycles without any request moving
    localparam int unsigned BYTE_TARGET   = 1250;
    localparam int unsigned HDR_SETTINGS  = 8;

    // Tracks the frame parse state and holds the temperatures still owed by the block.
    class temp_frame_scoreboard;
        t_byte       hdr[HdrCount];
        int unsigned pos;
        t_byte       sum;
        t_byte       int_byte;
        t_byte       frac_byte;
        t_temp       pending_temps[$];
        int unsigned temps_seen;
        int unsigned bad_sums;
        int unsigned restarts;
        int unsigned mismatches;

        function new();
            foreach (hdr[i]) hdr[i] = '0;
            pos        = 0;
            sum        = '0;
            int_byte   = '0;
            frac_byte  = '0;
            temps_seen = 0;
            bad_sums   = 0;
            restarts   = 0;
            mismatches = 0;
        endfunction

        function void set_header(t_cfg_idx idx, t_byte v);
            hdr[idx] = v;
        endfunction

        // Accepted byte: advance the frame and queue a temperature on a good checksum.
        function void take_byte(t_byte b);
            int m;
            // hunting, or a header byte that does not match: start over on this byte
            if (pos == 0 || (pos < HdrCount && b != hdr[pos])) begin
                if (pos != 0) restarts++;
                if (b == hdr[CFG_HDR_ONE]) begin
                    pos = 1;
                    sum = b;
                end else begin
                    pos = 0;
                    sum = '0;
                end
                return;
            end
            if (pos + 1 >= FRAME_LEN) begin
                if (sum == b) begin
                    m = int'(int_byte[SignBit-1:0]) * ScaleHundr + int'(frac_byte);
                    pending_temps.push_back(int_byte[SignBit] ? t_temp'(-m) : t_temp'(m));
                end else begin
                    bad_sums++;
                end
                pos = 0;
                sum = '0;
                return;
            end
            if (pos == IntOffset)  int_byte  = b;
            if (pos == FracOffset) frac_byte = b;
            sum += b;
            pos++;
        endfunction

        function void check_temp(t_temp got);
            t_temp want;
            if (pending_temps.size() == 0) begin
                mismatches++;
                $error("temperature_hundredths: no result expected, got %0d", got);
                return;
            end
            want = pending_temps.pop_front();
            temps_seen++;
            if (got !== want) begin
                mismatches++;
                $error("temperature_hundredths: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_byte       rx_byte   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_temp       temp_out;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    t_byte       cfg_data  = '0;

    temp_frame_scoreboard board = new();
    bit          idle_on    = 1'b1;  // cleared for stretches with back-to-back requests
    int unsigned bytes_sent = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    always #1 clk = ~clk;

    temperature_frame_parser_core #(.FRAME_LENGTH(FRAME_LEN)) dut (
        .i_clk                    (clk),
        .i_rst_n                  (rst_n),
        .i_in_valid               (in_valid),
        .o_in_stall               (in_stall),
        .i_rx_byte                (rx_byte),
        .o_out_valid              (out_valid),
        .i_out_stall              (out_stall),
        .o_temperature_hundredths (temp_out),
        .i_cfg_we                 (cfg_we),
        .i_cfg_index              (cfg_index),
        .i_cfg_data               (cfg_data)
    );

    function automatic int unsigned draw_wait();
        return idle_on ? $urandom_range(0, 10) : 0;
    endfunction

    // Temperature byte, biased toward the sign and range extremes.
    function automatic t_byte temp_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // Output side: check each accepted temperature, then stall for a drawn number of cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                board.check_temp(temp_out);
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: no request moving on either side for too long ends the run.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("temperature_frame_parser_core_test NOT OK");
                $finish;
            end
        end
    end

    // One byte request; valid stays high into the next call when no gap is drawn.
    task automatic send_byte(input t_byte b);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.take_byte(b);
        bytes_sent++;
    endtask

    // Frame from the current header: first cut bytes are sent; bad_hdr < HdrCount corrupts one.
    task automatic send_frame(input t_byte int_b, input t_byte frac_b, input bit bad_sum,
                              input int unsigned cut, input int unsigned bad_hdr);
        t_byte fr[FRAME_LEN];
        t_byte s;
        s = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            if (i < HdrCount)        fr[i] = board.hdr[i];
            else if (i == IntOffset)  fr[i] = int_b;
            else if (i == FracOffset) fr[i] = frac_b;
            else                      fr[i] = t_byte'($urandom);
            if (i == bad_hdr) fr[i] ^= t_byte'($urandom_range(1, 255));
            s += fr[i];
        end
        fr[FRAME_LEN-1] = bad_sum ? s ^ t_byte'($urandom_range(1, 255)) : s;
        for (int i = 0; i < cut; i++) send_byte(fr[i]);
    endtask

    // Drop valid, wait for every owed temperature, then let the pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_temps.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        board.set_header(idx, v);
    endtask

    task automatic set_headers(input t_byte h1, input t_byte h2, input t_byte h3, input t_byte h4);
        write_reg(CFG_HDR_ONE,   h1);
        write_reg(CFG_HDR_TWO,   h2);
        write_reg(CFG_HDR_THREE, h3);
        write_reg(CFG_HDR_FOUR,  h4);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned pick;
        int unsigned phase_goal;
        t_byte       h;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray byte while hunting, a repeated first header byte,
        // then full-scale positive, full-scale negative and negative zero.
        set_headers(8'h5A, 8'hA5, 8'h3C, 8'hC3);
        send_byte(8'h11);
        send_byte(8'h5A);
        send_frame(8'h7F, 8'hFF, 1'b0, FRAME_LEN, HdrCount);
        send_frame(8'hFF, 8'hFF, 1'b0, FRAME_LEN, HdrCount);
        send_frame(8'h80, 8'h00, 1'b0, FRAME_LEN, HdrCount);
        settle();

        // Random: a series of header settings, extremes first.
        for (int p = 0; p < HDR_SETTINGS; p++) begin
            case (p % 4)
                0: set_headers(8'h00, 8'h00, 8'h00, 8'h00);
                1: set_headers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: set_headers(t_byte'($urandom), t_byte'($urandom),
                               t_byte'($urandom), t_byte'($urandom));
                default: begin
                    // repeated bytes make header restarts keep the byte
                    h = t_byte'($urandom);
                    set_headers(h, h, t_byte'($urandom), t_byte'($urandom));
                end
            endcase
            phase_goal = bytes_sent + BYTE_TARGET / HDR_SETTINGS;
            while (bytes_sent < phase_goal) begin
                if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_frame(temp_byte(), temp_byte(), $urandom_range(0, 4) == 0,
                               FRAME_LEN, HdrCount);
                else if (pick < 85)
                    send_frame(temp_byte(), temp_byte(), 1'b0,
                               $urandom_range(1, FRAME_LEN - 1), HdrCount);
                else if (pick < 92)
                    send_frame(temp_byte(), temp_byte(), 1'b0,
                               FRAME_LEN, $urandom_range(1, HdrCount - 1));
                else
                    repeat ($urandom_range(1, 4)) send_byte(t_byte'($urandom));
            end
            // Leave a header half-received so the next setting applies mid-frame.
            if ($urandom_range(0, 1) == 1)
                send_frame(8'h00, 8'h00, 1'b0, $urandom_range(1, HdrCount - 1), HdrCount);
            settle();
        end

        idle_on = 1'b0;
        settle();

        $display("Covered %0d bytes over %0d header settings plus a directed set.",
                 bytes_sent, HDR_SETTINGS);
        $display("%0d temperatures checked, %0d bad checksums dropped, %0d header restarts.",
                 board.temps_seen, board.bad_sums, board.restarts);
        if (board.mismatches == 0) begin
            $display("temperature_frame_parser_core_test OK");
        end else begin
            $display("temperature_frame_parser_core_test NOT OK");
        end
        $finish;
    end

endmodule
